[rtl/prqt_pkg.sv]
// shared constants and types of the prime run quadratic tester
package prqt_pkg;

  // prime bitset geometry
  localparam int TABLE_WORDS = 1048576;
  localparam int TABLE_AW    = $clog2(TABLE_WORDS);

  // evaluated points per polynomial
  localparam int MAX_POINTS = 101;
  localparam int PT_AW      = $clog2(MAX_POINTS);

  // width of run and distinct counters, fixed by the result fields
  localparam int CNT_W = 7;

  // field widths
  localparam int INDEX_W = 20;
  localparam int WORD_W  = 32;
  localparam int COEF_W  = 16;
  localparam int VAL_W   = 32;

  // input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_RUN         = 2'd0;
  localparam logic [1:0] REG_REPORT_RUN      = 2'd1;
  localparam logic [1:0] REG_REPORT_DISTINCT = 2'd2;

  // configuration reset values
  localparam logic [CNT_W-1:0] MIN_RUN_RST         = 7'd40;
  localparam logic [CNT_W-1:0] REPORT_RUN_RST      = 7'd60;
  localparam logic [CNT_W-1:0] REPORT_DISTINCT_RST = 7'd40;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] min_run;
    logic [CNT_W-1:0] report_run;
    logic [CNT_W-1:0] report_distinct;
  } prqt_cfg_t;

  // one result item
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] run_length;
    logic [CNT_W-1:0] distinct_count;
  } prqt_result_t;

endpackage

[rtl/prqt_table.sv]
// prime bitset memory, one write port and one registered read port
module prqt_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [prqt_pkg::TABLE_AW-1:0] waddr_i,
  input  logic [prqt_pkg::WORD_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [prqt_pkg::TABLE_AW-1:0] raddr_i,
  output logic [prqt_pkg::WORD_W-1:0]   rdata_o
);

  logic [prqt_pkg::WORD_W-1:0] mem_q [0:prqt_pkg::TABLE_WORDS-1];
  logic [prqt_pkg::WORD_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/prqt_points.sv]
// store of evaluated point values, one write port and one registered read port
module prqt_points (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [prqt_pkg::PT_AW-1:0] waddr_i,
  input  logic [prqt_pkg::VAL_W-1:0] wdata_i,
  input  logic [prqt_pkg::PT_AW-1:0] raddr_i,
  output logic [prqt_pkg::VAL_W-1:0] rdata_o
);

  logic [prqt_pkg::VAL_W-1:0] mem_q [0:prqt_pkg::MAX_POINTS-1];
  logic [prqt_pkg::VAL_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/prqt_core.sv]
// sequencer that evaluates a quadratic point by point and searches for repeats
module prqt_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [prqt_pkg::COEF_W-1:0] coef_const_i,
  input  logic signed [prqt_pkg::COEF_W-1:0] coef_lin_i,
  input  logic signed [prqt_pkg::COEF_W-1:0] coef_quad_i,
  input  prqt_pkg::prqt_cfg_t                cfg_i,
  output logic                               idle_o,
  // prime bitset read
  output logic                               tbl_re_o,
  output logic [prqt_pkg::TABLE_AW-1:0]      tbl_raddr_o,
  input  logic [prqt_pkg::WORD_W-1:0]        tbl_rdata_i,
  // point store
  output logic                               pts_we_o,
  output logic [prqt_pkg::PT_AW-1:0]         pts_waddr_o,
  output logic [prqt_pkg::VAL_W-1:0]         pts_wdata_o,
  output logic [prqt_pkg::PT_AW-1:0]         pts_raddr_o,
  input  logic [prqt_pkg::VAL_W-1:0]         pts_rdata_i,
  // result
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output prqt_pkg::prqt_result_t             res_o
);

  localparam int CW = prqt_pkg::CNT_W;
  localparam int VW = prqt_pkg::VAL_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EVAL   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_XLOAD  = 8'b0001_0000,
    ST_XLATCH = 8'b0010_0000,
    ST_SCAN   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } prqt_state_e;

  prqt_state_e state_q, state_d;

  logic signed [VW-1:0] p_q, p_d;
  logic signed [VW-1:0] delta_q, delta_d;
  logic signed [VW-1:0] q2_q, q2_d;
  logic [VW-1:0]        a_q, a_d;
  logic [4:0]           bit_q, bit_d;
  logic [CW-1:0]        x_q, x_d;
  logic [CW-1:0]        run_q, run_d;
  logic [CW-1:0]        dist_q, dist_d;
  logic [CW-1:0]        y_q, y_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [VW-1:0]        vx_q, vx_d;

  logic [VW-1:0] abs_val;
  logic          beyond;
  logic          match;
  logic          hit;

  // magnitude of the current point and table range check
  assign abs_val = p_q[VW-1] ? VW'(-p_q) : VW'(p_q);
  assign beyond  = {5'b0, abs_val[VW-1:5]} >= VW'(prqt_pkg::TABLE_WORDS);

  // the shared compare against the held point value
  assign match = cmp_v_q && (pts_rdata_i == vx_q);

  // reporting rule
  assign hit = ((run_q >= cfg_i.report_run) || (dist_q >= cfg_i.report_distinct)) &&
               (dist_q > CW'(1));

  // sequencer
  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    delta_d     = delta_q;
    q2_d        = q2_q;
    a_d         = a_q;
    bit_d       = bit_q;
    x_d         = x_q;
    run_d       = run_q;
    dist_d      = dist_q;
    y_d         = y_q;
    cmp_v_d     = cmp_v_q;
    vx_d        = vx_q;
    tbl_re_o    = 1'b0;
    tbl_raddr_o = abs_val[5 +: prqt_pkg::TABLE_AW];
    pts_we_o    = 1'b0;
    pts_waddr_o = x_q[prqt_pkg::PT_AW-1:0];
    pts_wdata_o = a_q;
    pts_raddr_o = x_q[prqt_pkg::PT_AW-1:0];
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          p_d     = VW'(coef_const_i);
          delta_d = VW'(coef_lin_i) + VW'(coef_quad_i);
          q2_d    = VW'(coef_quad_i) <<< 1;
          x_d     = '0;
          run_d   = '0;
          dist_d  = '0;
          state_d = ST_EVAL;
        end
      end
      // look up the current magnitude in the bitset
      ST_EVAL: begin
        a_d   = abs_val;
        bit_d = abs_val[4:0];
        if (beyond) begin
          state_d = ST_DECIDE;
        end else begin
          tbl_re_o = 1'b1;
          state_d  = ST_CHECK;
        end
      end
      // prime: store the value and step the polynomial by its differences
      ST_CHECK: begin
        if (tbl_rdata_i[bit_q]) begin
          pts_we_o = 1'b1;
          run_d    = x_q + CW'(1);
          p_d      = p_q + delta_q;
          delta_d  = delta_q + q2_q;
          if (x_q == CW'(prqt_pkg::MAX_POINTS - 1)) begin
            state_d = ST_DECIDE;
          end else begin
            x_d     = x_q + CW'(1);
            state_d = ST_EVAL;
          end
        end else begin
          state_d = ST_DECIDE;
        end
      end
      // start the repeat search only for long enough runs
      ST_DECIDE: begin
        if (run_q >= cfg_i.min_run) begin
          dist_d = run_q;
          x_d    = CW'(1);
          if (run_q <= CW'(1)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_XLOAD;
          end
        end else begin
          dist_d  = '0;
          state_d = ST_FINISH;
        end
      end
      ST_XLOAD: begin
        state_d = ST_XLATCH;
      end
      ST_XLATCH: begin
        vx_d    = pts_rdata_i;
        y_d     = '0;
        cmp_v_d = 1'b0;
        state_d = ST_SCAN;
      end
      // read earlier values one per cycle, compare the one read last cycle
      ST_SCAN: begin
        pts_raddr_o = y_q[prqt_pkg::PT_AW-1:0];
        if (match) begin
          dist_d  = x_q;
          state_d = ST_FINISH;
        end else if (y_q == x_q) begin
          if (x_q + CW'(1) == run_q) begin
            state_d = ST_FINISH;
          end else begin
            x_d     = x_q + CW'(1);
            state_d = ST_XLOAD;
          end
        end else begin
          y_d     = y_q + CW'(1);
          cmp_v_d = 1'b1;
        end
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmp_v_q <= cmp_v_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    delta_q <= delta_d;
    q2_q    <= q2_d;
    a_q     <= a_d;
    bit_q   <= bit_d;
    x_q     <= x_d;
    run_q   <= run_d;
    dist_q  <= dist_d;
    y_q     <= y_d;
    vx_q    <= vx_d;
  end

  assign idle_o             = (state_q == ST_IDLE);
  assign res_o.hit          = hit;
  assign res_o.run_length   = run_q;
  assign res_o.distinct_count = dist_q;

endmodule

[rtl/prime_run_quadratic_tester.sv]
// top level of the prime run quadratic tester: stream ports, registers, memories
//
// A load item (tuser 0) writes one 32-bit word of the prime bitset and is
// taken with no result. A test item (tuser 1) evaluates |c + l*x + q*x^2|
// for x = 0, 1, ... with one adder pass per point and one bitset read per
// point. When the run R reaches min_run, a repeat search reads the point
// store one entry per cycle against one comparator, reloading the held
// value for each index x checked; otherwise the item ends right after the
// run. The block works on one item at a time and holds s_axis_tready low
// meanwhile; a finished result waits in an output register, so the next
// item is taken while it is still pending. The prime bitset has no reset:
// every word that a test can reach must be loaded first. Configuration is
// written over the APB port at addresses 0 (min_run), 4 (report_run) and
// 8 (report_distinct).
module prime_run_quadratic_tester (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // table_index[19:0], table_word[51:20], coef_const[67:52], coef_lin[83:68],
  // coef_quad[99:84], zero fill [103:100]
  input  logic [103:0] s_axis_tdata,
  // kind[0]
  input  logic         s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], run_length[7:1], distinct_count[14:8], zero fill [15]
  output logic [15:0]  m_axis_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = prqt_pkg::CNT_W;

  prqt_pkg::prqt_cfg_t    cfg_q;
  prqt_pkg::prqt_result_t core_res;
  prqt_pkg::prqt_result_t out_q;
  logic                   out_valid_q;

  logic        in_xfer;
  logic        load_we;
  logic        core_start;
  logic        core_idle;
  logic        cfg_we;
  logic [1:0]  reg_idx;

  logic [prqt_pkg::INDEX_W-1:0]       table_index;
  logic [prqt_pkg::WORD_W-1:0]        table_word;
  logic signed [prqt_pkg::COEF_W-1:0] coef_const;
  logic signed [prqt_pkg::COEF_W-1:0] coef_lin;
  logic signed [prqt_pkg::COEF_W-1:0] coef_quad;

  logic                          tbl_re;
  logic [prqt_pkg::TABLE_AW-1:0] tbl_raddr;
  logic [prqt_pkg::WORD_W-1:0]   tbl_rdata;
  logic                          pts_we;
  logic [prqt_pkg::PT_AW-1:0]    pts_waddr;
  logic [prqt_pkg::VAL_W-1:0]    pts_wdata;
  logic [prqt_pkg::PT_AW-1:0]    pts_raddr;
  logic [prqt_pkg::VAL_W-1:0]    pts_rdata;
  logic                          res_valid;
  logic                          res_ready;

  // input field unpacking
  assign table_index = s_axis_tdata[19:0];
  assign table_word  = s_axis_tdata[51:20];
  assign coef_const  = s_axis_tdata[67:52];
  assign coef_lin    = s_axis_tdata[83:68];
  assign coef_quad   = s_axis_tdata[99:84];

  // input transfer: loads go straight to the bitset, tests start the sequencer
  assign s_axis_tready = core_idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_xfer && (s_axis_tuser == prqt_pkg::KIND_LOAD) &&
                         ({12'b0, table_index} < 32'(prqt_pkg::TABLE_WORDS));
  assign core_start    = in_xfer && (s_axis_tuser == prqt_pkg::KIND_TEST);

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_run         <= prqt_pkg::MIN_RUN_RST;
      cfg_q.report_run      <= prqt_pkg::REPORT_RUN_RST;
      cfg_q.report_distinct <= prqt_pkg::REPORT_DISTINCT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        prqt_pkg::REG_MIN_RUN:         cfg_q.min_run         <= pwdata[CW-1:0];
        prqt_pkg::REG_REPORT_RUN:      cfg_q.report_run      <= pwdata[CW-1:0];
        prqt_pkg::REG_REPORT_DISTINCT: cfg_q.report_distinct <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      prqt_pkg::REG_MIN_RUN:         prdata = 32'(cfg_q.min_run);
      prqt_pkg::REG_REPORT_RUN:      prdata = 32'(cfg_q.report_run);
      prqt_pkg::REG_REPORT_DISTINCT: prdata = 32'(cfg_q.report_distinct);
      default:                       prdata = '0;
    endcase
  end

  // prime bitset
  prqt_table u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (prqt_pkg::TABLE_AW'(table_index)),
    .wdata_i (table_word),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // point value store
  prqt_points u_points (
    .clk_i   (clk_i),
    .we_i    (pts_we),
    .waddr_i (pts_waddr),
    .wdata_i (pts_wdata),
    .raddr_i (pts_raddr),
    .rdata_o (pts_rdata)
  );

  // evaluation and repeat search sequencer
  prqt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (core_start),
    .coef_const_i (coef_const),
    .coef_lin_i   (coef_lin),
    .coef_quad_i  (coef_quad),
    .cfg_i        (cfg_q),
    .idle_o       (core_idle),
    .tbl_re_o     (tbl_re),
    .tbl_raddr_o  (tbl_raddr),
    .tbl_rdata_i  (tbl_rdata),
    .pts_we_o     (pts_we),
    .pts_waddr_o  (pts_waddr),
    .pts_wdata_o  (pts_wdata),
    .pts_raddr_o  (pts_raddr),
    .pts_rdata_i  (pts_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (core_res)
  );

  // output register between the sequencer and the result stream
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.distinct_count, out_q.run_length, out_q.hit};

endmodule

[tb/prime_run_quadratic_checker.sv]
// checker of the prime run quadratic tester: bitset shadow, run scoring and result compare
module prime_run_quadratic_checker
  import prqt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // table_index[19:0], table_word[51:20], coef_const[67:52], coef_lin[83:68],
  // coef_quad[99:84], zero fill [103:100]
  input  logic [103:0] s_axis_tdata,
  // kind[0]
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], run_length[7:1], distinct_count[14:8], zero fill [15]
  input  logic [15:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready,
  output int           pending_o,
  output int           fail_count_o
);

  // field positions in the input and result words
  localparam int WORD_LSB  = INDEX_W;
  localparam int CONST_LSB = WORD_LSB + WORD_W;
  localparam int LIN_LSB   = CONST_LSB + COEF_W;
  localparam int QUAD_LSB  = LIN_LSB + COEF_W;
  localparam int RUN_LSB   = 1;
  localparam int DIST_LSB  = RUN_LSB + CNT_W;

  // shadow of the loaded bitset words and of the evaluated magnitudes
  bit   [WORD_W-1:0] prime_words [int];
  logic [VAL_W-1:0]  point_mags [MAX_POINTS];

  logic [CNT_W-1:0] min_run_q;
  logic [CNT_W-1:0] report_run_q;
  logic [CNT_W-1:0] report_distinct_q;

  // scores of accepted test items, oldest first
  prqt_result_t pending_scores [$];

  // values beyond the table never count as prime
  function automatic bit marked_prime(input longint unsigned mag);
    longint unsigned word_idx;
    word_idx = mag >> 5;
    if (word_idx >= TABLE_WORDS) return 1'b0;
    if (!prime_words.exists(int'(word_idx))) return 1'b0;
    return prime_words[int'(word_idx)][mag[4:0]];
  endfunction

  // run of prime magnitudes from x = 0, first repeat index and hit rule
  function automatic prqt_result_t score_quadratic(input logic signed [COEF_W-1:0] c,
                                                   input logic signed [COEF_W-1:0] l,
                                                   input logic signed [COEF_W-1:0] q);
    longint          val;
    longint unsigned mag;
    int              run;
    int              distinct;
    bit              found;
    prqt_result_t    res;
    run = 0;
    for (int x = 0; x < MAX_POINTS; x++) begin
      val = longint'(c) + longint'(x) * (longint'(l) + longint'(q) * longint'(x));
      mag = (val < 0) ? -val : val;
      if (!marked_prime(mag)) break;
      point_mags[x] = mag[VAL_W-1:0];
      run = x + 1;
    end
    distinct = 0;
    if (run >= int'(min_run_q)) begin
      distinct = run;
      found = 1'b0;
      for (int x = 1; x < run && !found; x++) begin
        for (int y = 0; y < x && !found; y++) begin
          if (point_mags[y] == point_mags[x]) begin
            distinct = x;
            found = 1'b1;
          end
        end
      end
    end
    res.hit = ((run >= int'(report_run_q)) || (distinct >= int'(report_distinct_q)))
              && (distinct > 1);
    res.run_length = CNT_W'(run);
    res.distinct_count = CNT_W'(distinct);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prqt_result_t want;
    logic [CNT_W-1:0] reg_val;
    if (!rst_ni) begin
      min_run_q = MIN_RUN_RST;
      report_run_q = REPORT_RUN_RST;
      report_distinct_q = REPORT_DISTINCT_RST;
      pending_scores.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MIN_RUN:         min_run_q = pwdata[CNT_W-1:0];
          REG_REPORT_RUN:      report_run_q = pwdata[CNT_W-1:0];
          REG_REPORT_DISTINCT: report_distinct_q = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      // register read back
      if (psel && penable && !pwrite && pready && paddr[3:2] != 2'd3) begin
        case (paddr[3:2])
          REG_MIN_RUN:    reg_val = min_run_q;
          REG_REPORT_RUN: reg_val = report_run_q;
          default:        reg_val = report_distinct_q;
        endcase
        if (prdata !== 32'(reg_val)) begin
          $error("prdata at %0d: expected %0d, actual %0d", paddr, reg_val, prdata);
          fail_count_o++;
        end
      end

      // result transfer against the oldest score
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_scores.size() == 0) begin
          $error("result transfer with no test item waiting: %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = pending_scores.pop_front();
          if (m_axis_tdata[0] !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, m_axis_tdata[0]);
            fail_count_o++;
          end
          if (m_axis_tdata[RUN_LSB +: CNT_W] !== want.run_length) begin
            $error("run_length: expected %0d, actual %0d", want.run_length,
                   m_axis_tdata[RUN_LSB +: CNT_W]);
            fail_count_o++;
          end
          if (m_axis_tdata[DIST_LSB +: CNT_W] !== want.distinct_count) begin
            $error("distinct_count: expected %0d, actual %0d", want.distinct_count,
                   m_axis_tdata[DIST_LSB +: CNT_W]);
            fail_count_o++;
          end
        end
      end

      // input transfer: load a bitset word or score a polynomial
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_LOAD) begin
          prime_words[int'(s_axis_tdata[INDEX_W-1:0])] = s_axis_tdata[WORD_LSB +: WORD_W];
        end else begin
          pending_scores.push_back(score_quadratic(s_axis_tdata[CONST_LSB +: COEF_W],
                                                   s_axis_tdata[LIN_LSB +: COEF_W],
                                                   s_axis_tdata[QUAD_LSB +: COEF_W]));
        end
      end
      pending_o = pending_scores.size();
    end
  end

endmodule

[tb/prime_run_quadratic_tester_test.sv]
// testbench top of the prime run quadratic tester: stimulus, stalls and verdict
module prime_run_quadratic_tester_test;
  import prqt_pkg::*;

  localparam int         CYCLE_LIMIT   = 12_000_000;
  localparam int         SIEVE_WORDS   = 512;
  localparam int         SIEVE_VALUES  = SIEVE_WORDS * 32;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_ITEMS   = 56;
  localparam int         SETTLE_CYCLES = 16;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  // content of bitset words that a test would read before any load
  typedef enum int {FILL_RANDOM, FILL_DENSE, FILL_ONES} fill_e;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int pending;
  int fail_count;
  int cycle_count = 0;
  int sent_count = 0;
  bit quiet_send = 1'b0;

  // words loaded so far and true primality below the sieve bound
  bit [WORD_W-1:0] loaded_words [int];
  bit              prime_flag [SIEVE_VALUES];

  prime_run_quadratic_tester i_dut (.*);

  prime_run_quadratic_checker i_checker (
    .*,
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("prime_run_quadratic_tester test failed");
      $finish;
    end
  end

  // first bitset word the walk of a test would read before it is loaded, else -1
  function automatic int missing_word(input logic signed [COEF_W-1:0] c,
                                      input logic signed [COEF_W-1:0] l,
                                      input logic signed [COEF_W-1:0] q);
    longint          val;
    longint unsigned mag;
    int              w;
    for (int x = 0; x < MAX_POINTS; x++) begin
      val = longint'(c) + longint'(x) * (longint'(l) + longint'(q) * longint'(x));
      mag = (val < 0) ? -val : val;
      if ((mag >> 5) >= TABLE_WORDS) return -1;
      w = int'(mag >> 5);
      if (!loaded_words.exists(w)) return w;
      if (!loaded_words[w][mag[4:0]]) return -1;
    end
    return -1;
  endfunction

  // one input transfer after a random gap
  task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [WORD_W-1:0] word,
                           input logic [COEF_W-1:0] c, input logic [COEF_W-1:0] l,
                           input logic [COEF_W-1:0] q);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, q, l, c, word, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == KIND_LOAD) loaded_words[int'(idx)] = word;
    sent_count++;
    if (sent_count % 32 == 0) quiet_send = ($urandom_range(0, 3) == 0);
  endtask

  // test item, preceded by loads of every word its walk would reach unloaded
  task automatic send_test(input logic signed [COEF_W-1:0] c,
                           input logic signed [COEF_W-1:0] l,
                           input logic signed [COEF_W-1:0] q, input fill_e fill);
    int                w;
    logic [WORD_W-1:0] content;
    w = missing_word(c, l, q);
    while (w >= 0) begin
      case (fill)
        FILL_ONES:  content = '1;
        FILL_DENSE: content = $urandom | $urandom;
        default:    content = $urandom;
      endcase
      send_item(KIND_LOAD, INDEX_W'(w), content, $urandom, $urandom, $urandom);
      w = missing_word(c, l, q);
    end
    send_item(KIND_TEST, $urandom, $urandom, c, l, q);
  endtask

  // setup and access cycle on the register port
  task automatic apb_access(input logic write, input logic [1:0] index,
                            input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_regs();
    apb_access(1'b0, REG_MIN_RUN, $urandom);
    apb_access(1'b0, REG_REPORT_RUN, $urandom);
    apb_access(1'b0, REG_REPORT_DISTINCT, $urandom);
    apb_access(1'b0, REG_UNUSED, $urandom);
  endtask

  // upper data bits are random, only the low field is kept
  task automatic configure(input int min_run, input int rep_run, input int rep_distinct);
    logic [31:0] data;
    data = $urandom;
    data[CNT_W-1:0] = CNT_W'(min_run);
    apb_access(1'b1, REG_MIN_RUN, data);
    data = $urandom;
    data[CNT_W-1:0] = CNT_W'(rep_run);
    apb_access(1'b1, REG_REPORT_RUN, data);
    data = $urandom;
    data[CNT_W-1:0] = CNT_W'(rep_distinct);
    apb_access(1'b1, REG_REPORT_DISTINCT, data);
    apb_access(1'b1, REG_UNUSED, $urandom);
    read_regs();
  endtask

  // wait until every scored item has come back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int stall;
    int taken;
    bit quiet_recv;
    m_axis_tready = 1'b0;
    taken = 0;
    quiet_recv = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet_recv ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
      if (taken % 24 == 0) quiet_recv = ($urandom_range(0, 2) == 0);
    end
  end

  // stimulus and verdict
  initial begin
    logic [WORD_W-1:0]        content;
    logic signed [COEF_W-1:0] c, l, q;
    int                       v, a, pick, min_run, rep_run, rep_distinct;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = KIND_LOAD;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // primality of small values
    for (int i = 0; i < SIEVE_VALUES; i++) prime_flag[i] = (i >= 2);
    for (int i = 2; i * i < SIEVE_VALUES; i++) begin
      if (prime_flag[i]) begin
        for (int m = i * i; m < SIEVE_VALUES; m += i) prime_flag[m] = 1'b0;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_regs();

    // true prime marks for the low words
    for (int w = 0; w < SIEVE_WORDS; w++) begin
      for (int b = 0; b < 32; b++) content[b] = prime_flag[w * 32 + b];
      send_item(KIND_LOAD, INDEX_W'(w), content, $urandom, $urandom, $urandom);
    end

    // classic quadratics and edge cases at the reset settings
    send_test(41, 1, 1, FILL_RANDOM);
    send_test(1601, -79, 1, FILL_RANDOM);
    send_test(-1601, 79, -1, FILL_RANDOM);
    send_test(41, -1, 1, FILL_RANDOM);
    send_test(41, 0, 0, FILL_RANDOM);
    send_test(2, 0, 0, FILL_RANDOM);
    send_test(0, 0, 0, FILL_RANDOM);
    send_test(1, 0, 0, FILL_RANDOM);
    send_test(29, 0, 2, FILL_RANDOM);
    send_test(3, -3, 0, FILL_RANDOM);
    // runs that climb out of the table
    send_test(5, 0, 32767, FILL_ONES);
    send_test(-32768, -32768, -32768, FILL_ONES);
    send_test(32767, 32767, 32767, FILL_ONES);
    // full run with no repeat, and a full run of one value
    send_test(11, -32768, 0, FILL_ONES);
    send_test(-32768, 0, 0, FILL_ONES);
    drain();

    // lowest settings
    configure(0, 0, 0);
    send_test(0, 0, 0, FILL_RANDOM);
    send_test(41, 0, 0, FILL_RANDOM);
    send_test(2, 1, 0, FILL_RANDOM);
    send_test(41, 1, 1, FILL_RANDOM);
    send_test(-32768, 32767, -32768, FILL_DENSE);
    drain();

    // highest settings
    configure(101, 101, 101);
    send_test(11, -32768, 0, FILL_ONES);
    send_test(41, 1, 1, FILL_RANDOM);
    send_test(1601, -79, 1, FILL_RANDOM);
    drain();

    // random phases
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       min_run = 0;
        1:       min_run = 101;
        default: min_run = $urandom_range(0, 60);
      endcase
      rep_run = $urandom_range(0, $urandom_range(0, 1) ? 50 : 101);
      rep_distinct = $urandom_range(0, $urandom_range(0, 1) ? 50 : 101);
      configure(min_run, rep_run, rep_distinct);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // stray load outside the true prime words
          send_item(KIND_LOAD, INDEX_W'($urandom_range(SIEVE_WORDS, TABLE_WORDS - 1)),
                    $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 45) begin
          // shifted Euler quadratic, mirrored runs with repeats
          a = $urandom_range(0, 40);
          c = a * a - a + 41;
          l = 1 - 2 * a;
          q = 1;
          if ($urandom_range(0, 1)) begin
            c = -c;
            l = -l;
            q = -q;
          end
          send_test(c, l, q, FILL_RANDOM);
        end else if (pick < 75) begin
          // prime constant with small slope and curvature
          v = $urandom_range(2, SIEVE_VALUES - 1);
          while (!prime_flag[v]) v = (v + 1 < SIEVE_VALUES) ? v + 1 : 2;
          c = $urandom_range(0, 1) ? -v : v;
          l = int'($urandom_range(0, 40)) - 20;
          q = int'($urandom_range(0, 6)) - 3;
          send_test(c, l, q, $urandom_range(0, 1) ? FILL_DENSE : FILL_RANDOM);
        end else if (pick < 90) begin
          // arbitrary coefficients
          send_test($urandom, $urandom, $urandom,
                    $urandom_range(0, 1) ? FILL_DENSE : FILL_RANDOM);
        end else begin
          // long runs through all-prime words
          l = int'($urandom_range(0, 16)) - 8;
          q = int'($urandom_range(0, 4)) - 2;
          send_test($urandom, l, q, FILL_ONES);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("prime_run_quadratic_tester test passed");
    end else begin
      $display("prime_run_quadratic_tester test failed");
    end
    $finish;
  end

endmodule
